FILE: design/prim_pkg.sv
// ----------------------------------------------------------------------------
// prim_pkg: shared types and constants of the range interface map
// Holds the table entry layout and the result status codes.
// ----------------------------------------------------------------------------
package prim_pkg;

   localparam int unsigned ADDR_W  = 128;
   localparam int unsigned IFACE_W = 8;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_OVERLAP = 2'd2;
   localparam status_type ST_VERSION = 2'd3;

   localparam logic       OP_LOOKUP = 1'b0;
   localparam logic       OP_INSERT = 1'b1;

   localparam logic [7:0] VER_IPV4 = 8'd4;
   localparam logic [7:0] VER_IPV6 = 8'd6;

   // An IPv4 range is stored zero-extended to 128 bits, so both families
   // share one entry layout and one comparator.
   typedef struct packed {
      logic [ADDR_W-1:0]  lower;
      logic [ADDR_W-1:0]  upper;
      logic [IFACE_W-1:0] iface;
   } entry_type;

   typedef struct packed {
      logic below;   // lower-side key lies below the entry's lower bound
      logic above;   // entry's upper bound lies below the upper-side key
   } cmp_type;

endpackage

FILE: design/prim_if.sv
// ----------------------------------------------------------------------------
// prim_if: request and response channels
// Valid/ready channels carrying one word of the map's input or result.
// ----------------------------------------------------------------------------
interface prim_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  version;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [7:0]  prefix_len;
   logic [7:0]  ingress_num;
   logic [7:0]  egress_num;

   modport source (output valid, op, version, src_addr_hi, src_addr_lo, dst_addr_hi,
                   dst_addr_lo, prefix_len, ingress_num, egress_num, input ready);
   modport sink   (input valid, op, version, src_addr_hi, src_addr_lo, dst_addr_hi,
                   dst_addr_lo, prefix_len, ingress_num, egress_num, output ready);
endinterface

interface prim_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ingress_match;
   logic [7:0] egress_match;
   logic [1:0] status;

   modport source (output valid, ingress_match, egress_match, status, input ready);
   modport sink   (input valid, ingress_match, egress_match, status, output ready);
endinterface

FILE: design/prefix_range_interface_map.sv
// ----------------------------------------------------------------------------
// prefix_range_interface_map: address range to interface lookup
// Four sorted range tables (IPv4/IPv6, source/destination) in one RAM,
// searched and updated by a sequencer around one shared comparator.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req_ch   in         op, version, addresses, prefix, interface numbers
//  rsp_ch   out        ingress_match, egress_match, status
//
// A lookup runs a binary search in each of two tables, reading and then comparing one
// entry per step; an insert compares every stored entry for overlap and then shifts
// entries up one place at a time to open the slot for the new range.
// Unknown versions go straight to the final state. Reset clears the entry counts.
// A new word is taken only while the sequencer is idle; a waiting result
// holds the sequencer in its final state until that word is taken.
module prefix_range_interface_map #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input logic       clock,
   input logic       reset,
   prim_req_if.sink  req_ch,
   prim_rsp_if.source rsp_ch
);
   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned AW = IW + 2;
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_LK_RD, S_LK_CMP, S_CK_START, S_CK_RD, S_CK_CMP,
      S_PUT_START, S_PUT_RD, S_PUT_CMP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic phase_ff, phase_in, ins_ff, ins_in, v6_ff, v6_in;
   logic ing_en_ff, ing_en_in, egr_en_ff, egr_en_in;
   logic [7:0] ing_ff, ing_in, egr_ff, egr_in;
   logic [prim_pkg::ADDR_W-1:0] a_ff, a_in, b_ff, b_in, ksrc_ff, ksrc_in, kdst_ff, kdst_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff [4];
   logic [CW-1:0] cnt_in [4];
   logic [7:0] im_ff, im_in, em_ff, em_in;
   prim_pkg::status_type st_ff, st_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_im_ff, rsp_im_in, rsp_em_ff, rsp_em_in;
   prim_pkg::status_type rsp_st_ff, rsp_st_in;

   logic [1:0] tid;
   logic [CW-1:0] cur_cnt;
   logic [CW:0] mid_sum;
   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   prim_pkg::entry_type ram_wdata, ram_rdata, new_entry;
   logic [prim_pkg::ADDR_W-1:0] key_lo, key_up, lk_key;
   prim_pkg::cmp_type cmp;

   // Request decode
   logic is_v4, is_v6;
   logic [7:0] p32, p128;
   logic [31:0] s4, m32;
   logic [prim_pkg::ADDR_W-1:0] s128, m128;

   assign is_v4 = req_ch.version == prim_pkg::VER_IPV4;
   assign is_v6 = req_ch.version == prim_pkg::VER_IPV6;
   assign p32   = (req_ch.prefix_len > 8'd32) ? 8'd32 : req_ch.prefix_len;
   assign p128  = (req_ch.prefix_len > 8'd128) ? 8'd128 : req_ch.prefix_len;
   assign s4    = req_ch.src_addr_lo[31:0];
   assign s128  = {req_ch.src_addr_hi, req_ch.src_addr_lo};
   assign m32   = ~({32{1'b1}} >> p32);
   assign m128  = ~({prim_pkg::ADDR_W{1'b1}} >> p128);

   assign tid       = {v6_ff, phase_ff};
   assign cur_cnt   = cnt_ff[tid];
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign lk_key    = phase_ff ? kdst_ff : ksrc_ff;
   assign new_entry = '{lower: a_ff, upper: b_ff, iface: (phase_ff ? egr_ff : ing_ff)};

   always_comb begin
      if (!ins_ff) begin
         key_lo = lk_key;
         key_up = lk_key;
      end else if (state_ff == S_CK_CMP) begin
         key_lo = b_ff;
         key_up = a_ff;
      end else begin
         key_lo = a_ff;
         key_up = a_ff;
      end
   end

   prim_cmp u_cmp (
      .key_lo (key_lo),
      .key_up (key_up),
      .entry  (ram_rdata),
      .result (cmp)
   );

   prim_ram #(
      .WIDTH ($bits(prim_pkg::entry_type)),
      .DEPTH (4 << IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready         = state_ff == S_IDLE;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ingress_match = rsp_im_ff;
   assign rsp_ch.egress_match  = rsp_em_ff;
   assign rsp_ch.status        = rsp_st_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ins_in       = ins_ff;
      v6_in        = v6_ff;
      ing_en_in    = ing_en_ff;
      egr_en_in    = egr_en_ff;
      ing_in       = ing_ff;
      egr_in       = egr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ksrc_in      = ksrc_ff;
      kdst_in      = kdst_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      im_in        = im_ff;
      em_in        = em_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_em_in    = rsp_em_ff;
      rsp_st_in    = rsp_st_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = {tid, idx_ff};
      ram_raddr    = {tid, idx_ff};
      ram_wdata    = new_entry;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               im_in     = '0;
               em_in     = '0;
               st_in     = prim_pkg::ST_OK;
               ins_in    = req_ch.op == prim_pkg::OP_INSERT;
               v6_in     = is_v6;
               ing_in    = req_ch.ingress_num;
               egr_in    = req_ch.egress_num;
               ing_en_in = req_ch.ingress_num != 8'd0;
               egr_en_in = req_ch.egress_num != 8'd0;
               if (is_v6) begin
                  a_in    = s128 & m128;
                  b_in    = s128 | ~m128;
                  ksrc_in = s128;
                  kdst_in = {req_ch.dst_addr_hi, req_ch.dst_addr_lo};
               end else begin
                  a_in    = {96'd0, s4 & m32};
                  b_in    = {96'd0, s4 | ~m32};
                  ksrc_in = {96'd0, s4};
                  kdst_in = {96'd0, req_ch.dst_addr_lo[31:0]};
               end
               if (!is_v4 && !is_v6) begin
                  st_in    = prim_pkg::ST_VERSION;
                  state_in = S_DONE;
               end else if (req_ch.op == prim_pkg::OP_LOOKUP) begin
                  phase_in = 1'b0;
                  lo_in    = '0;
                  hi_in    = cnt_ff[{is_v6, 1'b0}];
                  state_in = S_LK_RD;
               end else if (req_ch.ingress_num != 8'd0) begin
                  phase_in = 1'b0;
                  state_in = S_CK_START;
               end else if (req_ch.egress_num != 8'd0) begin
                  phase_in = 1'b1;
                  state_in = S_CK_START;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_LK_RD: begin
            if (lo_ff >= hi_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  lo_in    = '0;
                  hi_in    = cnt_ff[{v6_ff, 1'b1}];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               idx_in    = mid_sum[IW:1];
               ram_re    = 1'b1;
               ram_raddr = {tid, mid_sum[IW:1]};
               state_in  = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            state_in = S_LK_RD;
            if (!cmp.below && !cmp.above) begin
               if (phase_ff) begin
                  em_in = ram_rdata.iface;
               end else begin
                  im_in = ram_rdata.iface;
               end
               // Force the search of this table to end.
               lo_in = '0;
               hi_in = '0;
            end else if (cmp.above) begin
               lo_in = CW'(idx_ff) + CW'(1);
            end else begin
               hi_in = CW'(idx_ff);
            end
         end
         S_CK_START: begin
            if (cur_cnt == FULL_CNT) begin
               st_in    = prim_pkg::ST_FULL;
               state_in = S_DONE;
            end else begin
               idx_in   = '0;
               state_in = S_CK_RD;
            end
         end
         S_CK_RD: begin
            if (CW'(idx_ff) == cur_cnt) begin
               if (!phase_ff && egr_en_ff) begin
                  phase_in = 1'b1;
                  state_in = S_CK_START;
               end else begin
                  phase_in = !ing_en_ff;
                  state_in = S_PUT_START;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = S_CK_CMP;
            end
         end
         S_CK_CMP: begin
            if (!cmp.below && !cmp.above) begin
               st_in    = prim_pkg::ST_OVERLAP;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_CK_RD;
            end
         end
         S_PUT_START: begin
            idx_in   = cur_cnt[IW-1:0];
            state_in = S_PUT_RD;
         end
         S_PUT_RD: begin
            if (idx_ff == '0) begin
               ram_we      = 1'b1;
               cnt_in[tid] = cur_cnt + CW'(1);
               if (!phase_ff && egr_en_ff) begin
                  phase_in = 1'b1;
                  state_in = S_PUT_START;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = {tid, idx_ff - IW'(1)};
               state_in  = S_PUT_CMP;
            end
         end
         S_PUT_CMP: begin
            ram_we = 1'b1;
            // Stored lower bounds never equal the new one, so not below
            // means the entry sorts before the new range.
            if (!cmp.below) begin
               cnt_in[tid] = cur_cnt + CW'(1);
               if (!phase_ff && egr_en_ff) begin
                  phase_in = 1'b1;
                  state_in = S_PUT_START;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - IW'(1);
               state_in  = S_PUT_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_im_in    = im_ff;
               rsp_em_in    = em_ff;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < 4; t++) begin
            cnt_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      phase_ff  <= phase_in;
      ins_ff    <= ins_in;
      v6_ff     <= v6_in;
      ing_en_ff <= ing_en_in;
      egr_en_ff <= egr_en_in;
      ing_ff    <= ing_in;
      egr_ff    <= egr_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      ksrc_ff   <= ksrc_in;
      kdst_ff   <= kdst_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      im_ff     <= im_in;
      em_ff     <= em_in;
      st_ff     <= st_in;
      rsp_im_ff <= rsp_im_in;
      rsp_em_ff <= rsp_em_in;
      rsp_st_ff <= rsp_st_in;
   end
endmodule

FILE: design/prim_ram.sv
// ----------------------------------------------------------------------------
// prim_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prim_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

FILE: design/prim_cmp.sv
// ----------------------------------------------------------------------------
// prim_cmp: shared range comparator
// Compares one or two keys against the bounds of a table entry.
// ----------------------------------------------------------------------------
module prim_cmp (
   input  logic [prim_pkg::ADDR_W-1:0] key_lo,
   input  logic [prim_pkg::ADDR_W-1:0] key_up,
   input  prim_pkg::entry_type         entry,
   output prim_pkg::cmp_type           result
);
   assign result.below = key_lo < entry.lower;
   assign result.above = entry.upper < key_up;
endmodule

FILE: test/prefix_range_interface_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_range_interface_map_test: self-checking bench for the range map
// Drives inserts and lookups for both address families over the valid/ready
// channels, predicts every result from a local copy of the four range tables
// and checks each result word in order, under varying idle and stall rates.
// ----------------------------------------------------------------------------
module prefix_range_interface_map_test;

   localparam int DEPTH = 64;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        op;
      logic [7:0]  version;
      logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
      logic [7:0]  prefix_len, ingress_num, egress_num;
   } map_word_type;

   typedef struct {
      logic [7:0] ingress_match;
      logic [7:0] egress_match;
      prim_pkg::status_type status;
   } map_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prim_req_if req_ch ();
   prim_rsp_if rsp_ch ();

   prefix_range_interface_map #(.TABLE_ENTRIES(DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Tables: 0 IPv4 source, 1 IPv4 destination, 2 IPv6 source, 3 IPv6 destination.
   // IPv4 bounds are held zero-extended to 128 bits.
   logic [127:0] range_lower [4][DEPTH];
   logic [127:0] range_upper [4][DEPTH];
   logic [7:0]   range_iface [4][DEPTH];
   int           range_count [4];

   map_word_type   pending_words[$];
   map_result_type expected_results[$];
   map_word_type   offered_word;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   logic        hold_active;
   int          error_count = 0;
   longint      cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic prim_pkg::status_type check_room(int t, logic [127:0] lo,
                                                       logic [127:0] hi);
      if (range_count[t] >= DEPTH) return prim_pkg::ST_FULL;
      for (int i = 0; i < range_count[t]; i++)
         if (lo <= range_upper[t][i] && range_lower[t][i] <= hi) return prim_pkg::ST_OVERLAP;
      return prim_pkg::ST_OK;
   endfunction

   function automatic void insert_range(int t, logic [127:0] lo, logic [127:0] hi,
                                        logic [7:0] num);
      int pos = 0;
      while (pos < range_count[t] && range_lower[t][pos] < lo) pos++;
      for (int i = range_count[t]; i > pos; i--) begin
         range_lower[t][i] = range_lower[t][i-1];
         range_upper[t][i] = range_upper[t][i-1];
         range_iface[t][i] = range_iface[t][i-1];
      end
      range_lower[t][pos] = lo;
      range_upper[t][pos] = hi;
      range_iface[t][pos] = num;
      range_count[t]++;
   endfunction

   function automatic logic [7:0] search_range(int t, logic [127:0] key);
      int x = 0;
      int y = range_count[t] - 1;
      int m;
      while (x <= y) begin
         m = x + (y - x) / 2;
         if (key >= range_lower[t][m] && key <= range_upper[t][m]) return range_iface[t][m];
         if (range_upper[t][m] < key) x = m + 1;
         else y = m - 1;
      end
      return 8'd0;
   endfunction

   // Applies one accepted word to the local tables and returns its result.
   function automatic map_result_type apply_map_word(map_word_type w);
      map_result_type r;
      logic [127:0] src_key, dst_key, mask, lo, hi;
      int base, plen;
      r.ingress_match = 8'd0;
      r.egress_match  = 8'd0;
      r.status        = prim_pkg::ST_OK;
      if (w.version != prim_pkg::VER_IPV4 && w.version != prim_pkg::VER_IPV6) begin
         r.status = prim_pkg::ST_VERSION;
         return r;
      end
      if (w.version == prim_pkg::VER_IPV4) begin
         base    = 0;
         src_key = {96'd0, w.src_lo[31:0]};
         dst_key = {96'd0, w.dst_lo[31:0]};
         plen    = (w.prefix_len > 8'd32) ? 32 : int'(w.prefix_len);
         mask    = (plen == 0) ? 128'd0 : {96'd0, 32'hffff_ffff << (32 - plen)};
         lo      = src_key & mask;
         hi      = src_key | {96'd0, ~mask[31:0]};
      end else begin
         base    = 2;
         src_key = {w.src_hi, w.src_lo};
         dst_key = {w.dst_hi, w.dst_lo};
         plen    = (w.prefix_len > 8'd128) ? 128 : int'(w.prefix_len);
         mask    = (plen == 0) ? 128'd0 : ({128{1'b1}} << (128 - plen));
         lo      = src_key & mask;
         hi      = src_key | ~mask;
      end
      if (w.op == prim_pkg::OP_LOOKUP) begin
         r.ingress_match = search_range(base, src_key);
         r.egress_match  = search_range(base + 1, dst_key);
         return r;
      end
      if (w.ingress_num != 8'd0) r.status = check_room(base, lo, hi);
      if (r.status == prim_pkg::ST_OK && w.egress_num != 8'd0)
         r.status = check_room(base + 1, lo, hi);
      if (r.status == prim_pkg::ST_OK) begin
         if (w.ingress_num != 8'd0) insert_range(base, lo, hi, w.ingress_num);
         if (w.egress_num != 8'd0) insert_range(base + 1, lo, hi, w.egress_num);
      end
      return r;
   endfunction

   // Address that usually falls inside a stored range of table t.
   function automatic logic [127:0] pick_address(int t);
      logic [127:0] any = {$urandom, $urandom, $urandom, $urandom};
      int e;
      if (range_count[t] == 0 || $urandom_range(99) < 30) return any;
      e = int'($urandom_range(range_count[t] - 1));
      return range_lower[t][e] | (any & (range_lower[t][e] ^ range_upper[t][e]));
   endfunction

   function automatic logic [7:0] pick_iface();
      if ($urandom_range(99) < 15) return 8'd0;
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic map_word_type random_map_word();
      map_word_type w;
      logic [127:0] a;
      int r = int'($urandom_range(99));
      int base;
      w.op          = 1'($urandom_range(1));
      w.version     = 8'($urandom_range(255));
      w.src_hi      = {$urandom, $urandom};
      w.src_lo      = {$urandom, $urandom};
      w.dst_hi      = {$urandom, $urandom};
      w.dst_lo      = {$urandom, $urandom};
      w.prefix_len  = 8'($urandom_range(255));
      w.ingress_num = 8'($urandom_range(255));
      w.egress_num  = 8'($urandom_range(255));
      if (r < 4) return w;
      w.version = ($urandom_range(1) != 0) ? prim_pkg::VER_IPV6 : prim_pkg::VER_IPV4;
      base      = (w.version == prim_pkg::VER_IPV6) ? 2 : 0;
      w.op      = (r < 34) ? prim_pkg::OP_INSERT : prim_pkg::OP_LOOKUP;
      if (w.op == prim_pkg::OP_INSERT) begin
         if ($urandom_range(99) < 5) w.prefix_len = 8'($urandom_range(255, 129));
         else if (base == 0) w.prefix_len = 8'($urandom_range(32, 8));
         else w.prefix_len = 8'($urandom_range(128, 16));
         w.ingress_num = pick_iface();
         w.egress_num  = pick_iface();
         if ($urandom_range(99) < 20) begin
            a = pick_address(base + int'($urandom_range(1)));
            if (base == 0) w.src_lo[31:0] = a[31:0];
            else {w.src_hi, w.src_lo} = a;
         end
      end else begin
         a = pick_address(base);
         if (base == 0) w.src_lo[31:0] = a[31:0];
         else {w.src_hi, w.src_lo} = a;
         a = pick_address(base + 1);
         if (base == 0) w.dst_lo[31:0] = a[31:0];
         else {w.dst_hi, w.dst_lo} = a;
      end
      return w;
   endfunction

   task automatic queue_word(logic op, logic [7:0] ver, logic [63:0] sh, logic [63:0] sl,
                             logic [63:0] dh, logic [63:0] dl, logic [7:0] plen,
                             logic [7:0] ing, logic [7:0] egr);
      map_word_type w;
      w.op = op; w.version = ver; w.src_hi = sh; w.src_lo = sl;
      w.dst_hi = dh; w.dst_lo = dl; w.prefix_len = plen;
      w.ingress_num = ing; w.egress_num = egr;
      pending_words.push_back(w);
   endtask

   // Waits until every queued word has been taken and its result checked.
   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_results.size() != 0 || req_ch.valid)
         @(posedge clock);
   endtask

   // Request side: a new word is offered once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.op          <= prim_pkg::OP_LOOKUP;
         req_ch.version     <= 8'd0;
         req_ch.src_addr_hi <= 64'd0;
         req_ch.src_addr_lo <= 64'd0;
         req_ch.dst_addr_hi <= 64'd0;
         req_ch.dst_addr_lo <= 64'd0;
         req_ch.prefix_len  <= 8'd0;
         req_ch.ingress_num <= 8'd0;
         req_ch.egress_num  <= 8'd0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(apply_map_word(offered_word));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_word = pending_words.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.op          <= offered_word.op;
               req_ch.version     <= offered_word.version;
               req_ch.src_addr_hi <= offered_word.src_hi;
               req_ch.src_addr_lo <= offered_word.src_lo;
               req_ch.dst_addr_hi <= offered_word.dst_hi;
               req_ch.dst_addr_lo <= offered_word.dst_lo;
               req_ch.prefix_len  <= offered_word.prefix_len;
               req_ch.ingress_num <= offered_word.ingress_num;
               req_ch.egress_num  <= offered_word.egress_num;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver stall, counted in cycles.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = 400;
      end
      if (hold_left > 0) hold_left--;
      hold_active <= (hold_left > 0);
   end

   // Result side: checks each taken word and applies random or long stalls.
   always @(posedge clock) begin
      map_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.ingress_match !== want.ingress_match)
                  report_mismatch("ingress_match", int'(rsp_ch.ingress_match),
                                  int'(want.ingress_match));
               if (rsp_ch.egress_match !== want.egress_match)
                  report_mismatch("egress_match", int'(rsp_ch.egress_match),
                                  int'(want.egress_match));
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", int'(rsp_ch.status), int'(want.status));
            end
         end
         if (hold_active) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int send_pct [5] = '{0, 0, 51, 0, 17};
      int recv_pct [5] = '{0, 0, 0, 51, 17};
      for (int t = 0; t < 4; t++) range_count[t] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty lookups, overlap, clamping, extremes, unknown versions.
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV4, '1, '1, '1, '1, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV6, '0, '0, '1, '1, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '1, 64'hffff_ffff_0a00_0000, '0, '0,
                 8'd8, 8'd1, 8'd2);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '0, 64'h0a01_0000, '0, '0,
                 8'd16, 8'd3, 8'd0);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '0, 64'h0b01_0000, '0, '0,
                 8'd16, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '0, 64'hffff_ffff, '0, '0,
                 8'd255, 8'd255, 8'd255);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '0, 64'h0000_0000, '0, '0,
                 8'd33, 8'd0, 8'd7);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV4, '0, 64'h0a05_0000, '0, '0,
                 8'd24, 8'd0, 8'd9);
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV4, '1, 64'hffff_ffff_0a7f_0001, '1,
                 64'hffff_ffff_ffff_ffff, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV4, '0, 64'h0b00_0000, '0,
                 64'h0000_0000, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV6, 64'h2001_0db8_0000_0000, 64'h0,
                 '0, '0, 8'd32, 8'd10, 8'd11);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV6, 64'h2001_0db8_1234_0000, 64'h0,
                 '0, '0, 8'd48, 8'd12, 8'd0);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV6, '1, '1, '0, '0,
                 8'd255, 8'd255, 8'd255);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV6, 64'h3000_0000_0000_0001,
                 64'h8000_0000_0000_0000, '0, '0, 8'd65, 8'd20, 8'd21);
      queue_word(prim_pkg::OP_INSERT, prim_pkg::VER_IPV6, 64'h4000_0000_0000_0000, 64'h0,
                 '0, '0, 8'd64, 8'd0, 8'd22);
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV6, 64'h2001_0db8_ffff_0000, 64'h5,
                 '1, '1, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_LOOKUP, prim_pkg::VER_IPV6, 64'h3000_0000_0000_0001,
                 64'hffff_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h1234,
                 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_INSERT, 8'd5, '0, '0, '0, '0, 8'd0, 8'd1, 8'd1);
      queue_word(prim_pkg::OP_LOOKUP, 8'd255, '1, '1, '1, '1, 8'd0, 8'd0, 8'd0);
      queue_word(prim_pkg::OP_LOOKUP, 8'd0, '0, 64'h0a00_0001, '0, '0, 8'd0, 8'd0, 8'd0);
      wait_drained();

      // Random phases, refilled in small batches so lookups track the tables.
      for (int phase = 0; phase < 5; phase++) begin
         send_idle_pct = send_pct[phase];
         recv_idle_pct = recv_pct[phase];
         for (int batch = 0; batch < 8; batch++) begin
            if (phase == 1 && batch == 2) hold_token++;
            for (int i = 0; i < 45; i++) pending_words.push_back(random_map_word());
            wait_drained();
         end
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
